// File: rtl/esc_telemetry_poll_receiver_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry poll receiver checker
// ----------------------------------------------------------------------------
`ifndef ESC_TELEMETRY_POLL_RECEIVER_TOP_ASSERT_SVH
`define ESC_TELEMETRY_POLL_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define ESC_TLM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off during reset
`define ESC_TLM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/esc_tlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_tlm_pkg
// Shared constants, codes, types and the CRC-8 step of the telemetry receiver.
// ----------------------------------------------------------------------------
package esc_tlm_pkg;

  localparam int MAX_MOTORS  = 8;
  localparam int MOTOR_W     = $clog2(MAX_MOTORS);
  localparam int COUNT_W     = 4;
  localparam int FRAME_BYTES = 10;
  localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES + 1);
  localparam logic [7:0] AGE_INVALID = 8'd255;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  localparam logic [COUNT_W-1:0] RST_MOTOR_COUNT   = 4'd4;
  localparam logic [15:0]        RST_BOOT_WAIT     = 16'd5000;
  localparam logic [15:0]        RST_REPLY_TIMEOUT = 16'd100;
  localparam logic [7:0]         RST_MAX_AGE       = 8'd10;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_PROCESS = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [2:0] EV_REQUEST = 3'd0;
  localparam logic [2:0] EV_FRAME   = 3'd1;
  localparam logic [2:0] EV_CRC_ERR = 3'd2;
  localparam logic [2:0] EV_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_READ    = 3'd4;

  localparam logic [1:0] PH_STARTUP = 2'd0;
  localparam logic [1:0] PH_READY   = 2'd1;
  localparam logic [1:0] PH_PENDING = 2'd2;

  localparam logic [1:0] CFG_MOTOR_COUNT   = 2'd0;
  localparam logic [1:0] CFG_BOOT_WAIT     = 2'd1;
  localparam logic [1:0] CFG_REPLY_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_MAX_AGE       = 2'd3;

  typedef struct packed {
    logic       restart;
    logic       take;
    logic [7:0] data;
  } cap_ctrl_t;

  typedef struct packed {
    logic        done;
    logic        crc_ok;
    logic [7:0]  temperature;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] consumption;
    logic [15:0] rpm;
  } frame_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/esc_tlm_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_tlm_frame
// Reply byte capture with running CRC-8 and big-endian field unpacking.
// ----------------------------------------------------------------------------
module esc_tlm_frame (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire esc_tlm_pkg::cap_ctrl_t ctrl,
  output esc_tlm_pkg::frame_t        frm
);
  import esc_tlm_pkg::*;

  logic [BYTE_IDX_W-1:0] bytes_taken_r;
  logic [7:0]            crc_r;
  logic [7:0]            store_r [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_taken_r <= BYTE_IDX_W'(FRAME_BYTES);
      crc_r         <= 8'd0;
    end else if (ctrl.restart) begin
      bytes_taken_r <= '0;
      crc_r         <= 8'd0;
    end else if (ctrl.take && (bytes_taken_r < BYTE_IDX_W'(FRAME_BYTES))) begin
      if (bytes_taken_r < BYTE_IDX_W'(FRAME_BYTES - 1)) begin
        crc_r <= crc8_step(crc_r, ctrl.data);
      end
      bytes_taken_r <= bytes_taken_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.restart && ctrl.take && (bytes_taken_r < BYTE_IDX_W'(FRAME_BYTES))) begin
      store_r[bytes_taken_r] <= ctrl.data;
    end
  end

  always_comb begin
    frm.done        = (bytes_taken_r >= BYTE_IDX_W'(FRAME_BYTES));
    frm.crc_ok      = (crc_r == store_r[FRAME_BYTES-1]);
    frm.temperature = store_r[0];
    frm.voltage     = {store_r[1], store_r[2]};
    frm.current     = {store_r[3], store_r[4]};
    frm.consumption = {store_r[5], store_r[6]};
    frm.rpm         = {store_r[7], store_r[8]};
  end

endmodule
`default_nettype wire

// File: rtl/esc_telemetry_poll_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_telemetry_poll_receiver_top
// Round-robin telemetry poller for motor speed controllers with CRC-8 check.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result register is stalled: each item
// passes an input register, one level of decode, CRC compare and per-motor
// table update, then a result register. Only a stalled result register holds
// back the input side. Items of kind byte give no result; process calls give
// request, frame, CRC error or timeout events, or no result during startup or
// while a reply is awaited; reads give the stored data of the selected motor,
// zeroed but for temperature when its age is above the limit or the motor is
// not below the effective motor count. No clearing pass is needed after reset.
module esc_telemetry_poll_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // rx_byte, now_ms, motor_select, zero pad
  input  wire logic [1:0]  in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // motor, temperature, voltage, current,
                                       // consumption, rpm, data_age, valid_res, pad
  output logic [2:0]       out_tuser,  // event_res
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import esc_tlm_pkg::*;

  logic [COUNT_W-1:0] motor_count_r;
  logic [15:0]        boot_wait_r;
  logic [15:0]        reply_timeout_r;
  logic [7:0]         max_age_r;

  logic               s1_valid_r;
  logic [1:0]         s1_cmd_r;
  logic [7:0]         s1_byte_r;
  logic [31:0]        s1_now_r;
  logic [MOTOR_W-1:0] s1_sel_r;

  logic [1:0]         phase_r, phase_nxt;
  logic [MOTOR_W-1:0] cur_motor_r, cur_motor_nxt;
  logic [31:0]        req_time_r, req_time_nxt;

  logic [7:0]  age_r  [MAX_MOTORS];
  logic [7:0]  temp_r [MAX_MOTORS];
  logic [15:0] volt_r [MAX_MOTORS];
  logic [15:0] curr_r [MAX_MOTORS];
  logic [15:0] cons_r [MAX_MOTORS];
  logic [15:0] rpm_r  [MAX_MOTORS];

  logic               out_valid_r, out_valid_nxt;
  logic [87:0]        out_data_r;
  logic [2:0]         out_user_r;

  logic               fire;
  logic [COUNT_W-1:0] eff_count;
  logic [MOTOR_W-1:0] cur_m;
  logic [COUNT_W-1:0] next_m;
  logic [MOTOR_W-1:0] next_motor;
  logic [7:0]         age_cur;
  logic [7:0]         age_inc;
  logic [7:0]         age_sel;
  logic [31:0]        elapsed;
  logic               timed_out;

  logic               age_wr;
  logic [7:0]         age_wr_val;
  logic               data_wr;

  logic               res_valid;
  logic [2:0]         res_event;
  logic [MOTOR_W-1:0] res_motor;
  logic [7:0]         res_temp;
  logic [15:0]        res_volt;
  logic [15:0]        res_curr;
  logic [15:0]        res_cons;
  logic [15:0]        res_rpm;
  logic [7:0]         res_age;
  logic               res_ok;

  cap_ctrl_t          cap;
  frame_t             frm;

  esc_tlm_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cap),
    .frm   (frm)
  );

  assign cfg_ready  = 1'b1;
  assign fire       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || fire;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_count_r   <= RST_MOTOR_COUNT;
      boot_wait_r     <= RST_BOOT_WAIT;
      reply_timeout_r <= RST_REPLY_TIMEOUT;
      max_age_r       <= RST_MAX_AGE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MOTOR_COUNT:   motor_count_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_BOOT_WAIT:     boot_wait_r     <= cfg_wdata;
        CFG_REPLY_TIMEOUT: reply_timeout_r <= cfg_wdata;
        CFG_MAX_AGE:       max_age_r       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
      s1_now_r  <= in_tdata[39:8];
      s1_sel_r  <= in_tdata[40 +: MOTOR_W];
    end
  end

  always_comb begin
    if (motor_count_r == '0) begin
      eff_count = COUNT_W'(1);
    end else if (motor_count_r > COUNT_W'(MAX_MOTORS)) begin
      eff_count = COUNT_W'(MAX_MOTORS);
    end else begin
      eff_count = motor_count_r;
    end
    cur_m      = (COUNT_W'(cur_motor_r) >= eff_count) ? '0 : cur_motor_r;
    next_m     = COUNT_W'(cur_m) + 1'b1;
    next_motor = (next_m >= eff_count) ? '0 : next_m[MOTOR_W-1:0];
    age_cur    = age_r[cur_m];
    age_inc    = (age_cur < AGE_INVALID) ? age_cur + 8'd1 : age_cur;
    age_sel    = age_r[s1_sel_r];
    elapsed    = s1_now_r - req_time_r;
    timed_out  = (elapsed >= {16'd0, reply_timeout_r});
  end

  always_comb begin
    phase_nxt     = phase_r;
    cur_motor_nxt = cur_motor_r;
    req_time_nxt  = req_time_r;
    cap.restart   = 1'b0;
    cap.take      = 1'b0;
    cap.data      = s1_byte_r;
    age_wr        = 1'b0;
    age_wr_val    = age_inc;
    data_wr       = 1'b0;
    res_valid     = 1'b0;
    res_event     = EV_REQUEST;
    res_motor     = cur_m;
    res_temp      = 8'd0;
    res_volt      = 16'd0;
    res_curr      = 16'd0;
    res_cons      = 16'd0;
    res_rpm       = 16'd0;
    res_age       = age_cur;
    res_ok        = 1'b0;
    if (fire) begin
      case (s1_cmd_r)
        CMD_BYTE: begin
          cap.take = 1'b1;
        end
        CMD_READ: begin
          res_valid = 1'b1;
          res_event = EV_READ;
          res_motor = s1_sel_r;
          res_temp  = temp_r[s1_sel_r];
          res_age   = age_sel;
          if ((COUNT_W'(s1_sel_r) < eff_count) && (age_sel <= max_age_r)) begin
            res_ok   = 1'b1;
            res_volt = volt_r[s1_sel_r];
            res_curr = curr_r[s1_sel_r];
            res_cons = cons_r[s1_sel_r];
            res_rpm  = rpm_r[s1_sel_r];
          end
        end
        CMD_PROCESS: begin
          cur_motor_nxt = cur_m;
          case (phase_r)
            PH_STARTUP: begin
              if (s1_now_r >= {16'd0, boot_wait_r}) begin
                phase_nxt = PH_READY;
              end
            end
            PH_READY: begin
              req_time_nxt = s1_now_r;
              cap.restart  = 1'b1;
              phase_nxt    = PH_PENDING;
              res_valid    = 1'b1;
              res_event    = EV_REQUEST;
              res_ok       = (age_cur <= max_age_r);
            end
            PH_PENDING: begin
              if (timed_out || frm.done) begin
                res_valid     = 1'b1;
                phase_nxt     = PH_READY;
                cur_motor_nxt = next_motor;
                if (!timed_out && frm.crc_ok) begin
                  age_wr     = 1'b1;
                  age_wr_val = 8'd0;
                  data_wr    = 1'b1;
                  res_event  = EV_FRAME;
                  res_temp   = frm.temperature;
                  res_volt   = frm.voltage;
                  res_curr   = frm.current;
                  res_cons   = frm.consumption;
                  res_rpm    = frm.rpm;
                  res_age    = 8'd0;
                  res_ok     = 1'b1;
                end else begin
                  age_wr    = 1'b1;
                  res_event = timed_out ? EV_TIMEOUT : EV_CRC_ERR;
                  res_age   = age_inc;
                  res_ok    = (age_inc <= max_age_r);
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STARTUP;
      cur_motor_r <= '0;
      req_time_r  <= 32'd0;
    end else begin
      phase_r     <= phase_nxt;
      cur_motor_r <= cur_motor_nxt;
      req_time_r  <= req_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MOTORS; i++) begin
        age_r[i]  <= AGE_INVALID;
        temp_r[i] <= 8'd0;
        volt_r[i] <= 16'd0;
        curr_r[i] <= 16'd0;
        cons_r[i] <= 16'd0;
        rpm_r[i]  <= 16'd0;
      end
    end else begin
      if (age_wr) begin
        age_r[cur_m] <= age_wr_val;
      end
      if (data_wr) begin
        temp_r[cur_m] <= frm.temperature;
        volt_r[cur_m] <= frm.voltage;
        curr_r[cur_m] <= frm.current;
        cons_r[cur_m] <= frm.consumption;
        rpm_r[cur_m]  <= frm.rpm;
      end
    end
  end

  assign out_valid_nxt = fire ? res_valid : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_user_r <= res_event;
      out_data_r <= {4'd0, res_ok, res_age, res_rpm, res_cons, res_curr, res_volt,
                     res_temp, res_motor};
    end
  end

endmodule
`default_nettype wire

// File: rtl/esc_tlm_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_tlm_chk
// Port-level checks on the telemetry poll receiver, bound to its top level.
// ----------------------------------------------------------------------------
`include "esc_telemetry_poll_receiver_top_assert.svh"

module esc_tlm_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,  // motor, temperature, voltage, current,
                                      // consumption, rpm, data_age, valid_res, pad
  input wire logic [2:0]  out_tuser   // event_res
);
  import esc_tlm_pkg::*;

  logic ev_zero_data;

  assign ev_zero_data = (out_tuser == EV_REQUEST) || (out_tuser == EV_CRC_ERR) ||
                        (out_tuser == EV_TIMEOUT);

  `ESC_TLM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled item changed")

  `ESC_TLM_ASSERT_IMP(a_event_no_data, out_tvalid && ev_zero_data,
    out_tdata[74:3] == '0, "poll event carries motor data")

  `ESC_TLM_ASSERT_IMP(a_frame_fresh, out_tvalid && (out_tuser == EV_FRAME),
    (out_tdata[82:75] == 8'd0) && out_tdata[83], "good frame without fresh age")

  `ESC_TLM_ASSERT_IMP(a_read_stale_zero,
    out_tvalid && (out_tuser == EV_READ) && !out_tdata[83],
    out_tdata[74:11] == '0, "stale read carries data beyond temperature")

  `ESC_TLM_ASSERT_IMP(a_ready_when_idle, !out_tvalid,
    in_tready, "input held off with the result side empty")

endmodule

bind esc_telemetry_poll_receiver_top esc_tlm_chk u_esc_tlm_chk (.*);
`default_nettype wire
